>>> design/ddmix_pkg.sv
// ----------------------------------------------------------------------------
// ddmix_pkg
// Shared types and constants of the differential drive mixer.
// ----------------------------------------------------------------------------
package ddmix_pkg;

    localparam int AXIS_W  = 16;
    localparam int SPEED_W = 16;
    localparam int CFG_W   = 15;
    localparam int DUR_W   = 16;
    localparam int IDX_W   = 1;
    localparam int CSU_W   = 19;

    localparam logic [CFG_W-1:0] ONE_Q14        = 15'd16384;
    localparam logic [CFG_W-1:0] GAIN_RESET     = 15'd16384;
    localparam logic [CFG_W-1:0] DEAD_ZONE_RST  = 15'd1639;

    localparam logic [IDX_W-1:0] REG_SPEED_GAIN = 1'b0;
    localparam logic [IDX_W-1:0] REG_DEAD_ZONE  = 1'b1;

    localparam logic OP_COMMAND = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    typedef struct packed {
        logic                     operation;
        logic signed [AXIS_W-1:0] x_axis;
        logic signed [AXIS_W-1:0] y_axis;
        logic [DUR_W-1:0]         duration_ms;
    } t_mix_in;

    typedef struct packed {
        logic signed [SPEED_W-1:0] left_speed;
        logic signed [SPEED_W-1:0] right_speed;
        logic                      timed_out;
    } t_mix_out;

    typedef struct packed {
        logic             ge;
        logic [CSU_W-1:0] diff;
    } t_csu_res;

endpackage

>>> design/ddmix_csu.sv
// ----------------------------------------------------------------------------
// ddmix_csu
// Compare-subtract unit shared by the square root and the divide steps.
// ----------------------------------------------------------------------------
module ddmix_csu
    import ddmix_pkg::*;
(
    input  logic [CSU_W-1:0] i_a,
    input  logic [CSU_W-1:0] i_b,
    output t_csu_res         o_res
);

    logic [CSU_W:0] w_sub;

    // borrow out of the extra bit means a < b
    assign w_sub      = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.ge   = ~w_sub[CSU_W];
    assign o_res.diff = w_sub[CSU_W-1:0];

endmodule

>>> design/differential_drive_mixer.sv
// ----------------------------------------------------------------------------
// differential_drive_mixer
// Joystick vector to left/right track speeds, with a millisecond auto stop.
// ----------------------------------------------------------------------------
// A command word runs the square root and, when the vector length exceeds 1.0
// and both speeds must be renormalized, the divide; a tick word leaves the
// input side ready unless it produces the stop word. The work is done by one
// compare-subtract unit that runs 16 square root steps and, when needed, 15
// restoring divide steps, plus one 16x16 multiplier used for the two squares
// and the two gain products. The input side is not ready while a word is in
// work; a finished word waits in an output register, so the next word can be
// accepted before the previous result is taken.
module differential_drive_mixer
    import ddmix_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_mix_in          i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_mix_out         o_out_word,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SQX    = 4'd1;
    localparam logic [3:0] S_SQY    = 4'd2;
    localparam logic [3:0] S_SQRT   = 4'd3;
    localparam logic [3:0] S_PREP   = 4'd4;
    localparam logic [3:0] S_DIV    = 4'd5;
    localparam logic [3:0] S_GAIN_N = 4'd6;
    localparam logic [3:0] S_GAIN_T = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    localparam logic [3:0] SQRT_LAST = 4'd15;
    localparam logic [3:0] DIV_LAST  = 4'd14;

    localparam logic [32:0] CNT_MAX = (33'd1 << COUNT_WIDTH) - 33'd1;

    // control
    logic [3:0]             r_state;
    logic [3:0]             r_cnt;
    logic [COUNT_WIDTH-1:0] r_remaining;
    logic [CFG_W-1:0]       r_gain;
    logic [CFG_W-1:0]       r_dead_zone;
    logic                   r_out_valid;

    // datapath
    logic [AXIS_W-1:0]      r_xmag, r_ymag;
    logic                   r_xneg, r_yneg;
    logic [31:0]            r_rad;
    logic [CSU_W-1:0]       r_rem;
    logic [15:0]            r_root;
    logic [16:0]            r_drem;
    logic [14:0]            r_quot;
    logic [15:0]            r_mag_n, r_mag_t;
    logic                   r_sign_n, r_sign_t;
    logic [SPEED_W-1:0]     r_res_n;
    logic [SPEED_W-1:0]     r_left, r_right;
    logic                   r_tout;
    t_mix_out               r_out;

    logic                   w_in_acc;
    logic                   w_out_load;
    logic [AXIS_W-1:0]      w_xabs, w_yabs;
    logic                   w_xz, w_yz;
    logic                   w_arm;
    logic [32:0]            w_dur_ext;
    logic [COUNT_WIDTH-1:0] w_load;
    logic [15:0]            w_mul_a, w_mul_b;
    logic [31:0]            w_prod;
    logic [15:0]            w_gm;
    logic [SPEED_W-1:0]     w_gs;
    logic [CSU_W-1:0]       w_rem_sh;
    logic [CSU_W-1:0]       w_csu_a, w_csu_b;
    t_csu_res               w_csu;
    logic                   w_xzero, w_pivot;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_load  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // dead zone on the raw axes
    assign w_xabs = i_in_word.x_axis[AXIS_W-1] ? AXIS_W'(-i_in_word.x_axis)
                                               : AXIS_W'(i_in_word.x_axis);
    assign w_yabs = i_in_word.y_axis[AXIS_W-1] ? AXIS_W'(-i_in_word.y_axis)
                                               : AXIS_W'(i_in_word.y_axis);
    assign w_xz   = w_xabs < {1'b0, r_dead_zone};
    assign w_yz   = w_yabs < {1'b0, r_dead_zone};

    // vector still nonzero after the dead zone
    assign w_arm  = (!w_xz && (w_xabs != '0)) || (!w_yz && (w_yabs != '0));

    assign w_dur_ext = {17'd0, i_in_word.duration_ms};
    assign w_load    = (w_dur_ext > CNT_MAX) ? CNT_MAX[COUNT_WIDTH-1:0]
                                             : w_dur_ext[COUNT_WIDTH-1:0];

    assign w_xzero = (r_xmag == '0);
    assign w_pivot = w_xzero && (r_ymag != '0);

    // shared multiplier
    always_comb begin
        unique case (r_state)
            S_SQX: begin
                w_mul_a = r_xmag;
                w_mul_b = r_xmag;
            end
            S_SQY: begin
                w_mul_a = r_ymag;
                w_mul_b = r_ymag;
            end
            S_GAIN_N: begin
                w_mul_a = r_mag_n;
                w_mul_b = {1'b0, r_gain};
            end
            default: begin
                w_mul_a = r_mag_t;
                w_mul_b = {1'b0, r_gain};
            end
        endcase
    end

    assign w_prod = 32'(w_mul_a) * 32'(w_mul_b);
    assign w_gm   = w_prod[29:14];
    assign w_gs   = (r_state == S_GAIN_N ? r_sign_n : r_sign_t) ? (~w_gm + 16'd1) : w_gm;

    // shared compare-subtract operands
    assign w_rem_sh = {r_rem[16:0], r_rad[31:30]};

    always_comb begin
        if (r_state == S_DIV) begin
            w_csu_a = {2'b00, r_drem};
            w_csu_b = {3'b000, r_root};
        end else begin
            w_csu_a = w_rem_sh;
            w_csu_b = {1'b0, r_root, 2'b01};
        end
    end

    ddmix_csu u_csu (
        .i_a   (w_csu_a),
        .i_b   (w_csu_b),
        .o_res (w_csu)
    );

    // sequencer, countdown, configuration, output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_remaining <= '0;
            r_gain      <= GAIN_RESET;
            r_dead_zone <= DEAD_ZONE_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_SPEED_GAIN: r_gain      <= (i_cfg_data > ONE_Q14) ? ONE_Q14
                                                                          : i_cfg_data;
                    REG_DEAD_ZONE:  r_dead_zone <= i_cfg_data;
                    default: ;
                endcase
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_in_word.operation == OP_TICK) begin
                            if (r_remaining != '0) begin
                                r_remaining <= r_remaining - COUNT_WIDTH'(1);
                                if (r_remaining == COUNT_WIDTH'(1)) begin
                                    r_state <= S_DONE;
                                end
                            end
                        end else begin
                            if (i_in_word.duration_ms != '0 && w_arm) begin
                                r_remaining <= w_load;
                            end else begin
                                r_remaining <= '0;
                            end
                            r_state <= S_SQX;
                        end
                    end
                end
                S_SQX: r_state <= S_SQY;
                S_SQY: begin
                    r_cnt   <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == SQRT_LAST) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_cnt <= '0;
                    if (r_root > 16'(ONE_Q14)) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_GAIN_N;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == DIV_LAST) begin
                        r_state <= S_GAIN_N;
                    end
                end
                S_GAIN_N: r_state <= S_GAIN_T;
                S_GAIN_T: r_state <= S_DONE;
                S_DONE: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_xmag <= w_xz ? '0 : w_xabs;
            r_ymag <= w_yz ? '0 : w_yabs;
            r_xneg <= i_in_word.x_axis[AXIS_W-1] && !w_xz;
            r_yneg <= i_in_word.y_axis[AXIS_W-1] && !w_yz;
            r_left  <= '0;
            r_right <= '0;
            r_tout  <= (i_in_word.operation == OP_TICK);
        end

        unique case (r_state)
            S_SQX: r_rad <= w_prod;
            S_SQY: begin
                r_rad  <= r_rad + w_prod;
                r_rem  <= '0;
                r_root <= '0;
            end
            S_SQRT: begin
                r_rem  <= w_csu.ge ? w_csu.diff : w_rem_sh;
                r_root <= {r_root[14:0], w_csu.ge};
                r_rad  <= {r_rad[29:0], 2'b00};
            end
            S_PREP: begin
                r_sign_n <= r_xneg;
                r_sign_t <= w_pivot ? 1'b1 : r_xneg;
                r_drem   <= {1'b0, w_pivot ? r_root : (r_root - r_ymag)};
                r_mag_t  <= w_pivot ? r_root : (r_root - r_ymag);
                r_mag_n  <= (r_root > 16'(ONE_Q14)) ? 16'(ONE_Q14) : r_root;
                r_quot   <= '0;
            end
            S_DIV: begin
                // restoring step; remainder shifts after the subtract
                r_drem <= {(w_csu.ge ? w_csu.diff[15:0] : r_drem[15:0]), 1'b0};
                r_quot <= {r_quot[13:0], w_csu.ge};
                if (r_cnt == DIV_LAST) begin
                    r_mag_t <= {r_quot, w_csu.ge};
                end
            end
            S_GAIN_N: r_res_n <= w_gs;
            S_GAIN_T: begin
                r_tout <= 1'b0;
                if (r_yneg) begin
                    r_left  <= r_res_n;
                    r_right <= w_gs;
                end else begin
                    r_left  <= w_gs;
                    r_right <= r_res_n;
                end
            end
            default: ;
        endcase

        if (w_out_load) begin
            r_out.left_speed  <= r_left;
            r_out.right_speed <= r_right;
            r_out.timed_out   <= r_tout;
        end
    end

endmodule

>>> design/ddmix_chk.sv
// ----------------------------------------------------------------------------
// ddmix_chk
// Port-level checks of the differential drive mixer, bound to the top level.
// ----------------------------------------------------------------------------
module ddmix_chk
    import ddmix_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input t_mix_in          i_in_word,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input t_mix_out         o_out_word,
    input logic             i_cfg_we
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // the automatic stop carries zero speeds
    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.timed_out |->
            o_out_word.left_speed == '0 && o_out_word.right_speed == '0)
        else $error("stop word with nonzero speed");

    // speeds stay within plus or minus one
    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            o_out_word.left_speed >= -16'sd16384 && o_out_word.left_speed <= 16'sd16384 &&
            o_out_word.right_speed >= -16'sd16384 && o_out_word.right_speed <= 16'sd16384)
        else $error("speed out of range");

    // a command word keeps the input side busy
    a_cmd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_word.operation == OP_COMMAND |=> !o_in_ready)
        else $error("ready right after a command word");

    // the user is to write registers only while nothing is in work; the mixer does not enforce it
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> o_in_ready && !o_out_valid)
        else $error("register write while a word is in work");

endmodule

bind differential_drive_mixer ddmix_chk u_ddmix_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word),
    .i_cfg_we    (i_cfg_we)
);

>>> verif/tb_differential_drive_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_differential_drive_mixer
// Drives joystick commands and millisecond ticks into the mixer with random
// gaps and output stalls, predicts every track speed word and auto stop word
// from a behavioral mixer kept in the bench, and checks each word in order.
// ----------------------------------------------------------------------------
module tb_differential_drive_mixer;
    import ddmix_pkg::*;

    localparam int UNITY_Q14     = 16384;
    localparam int SETTLE_CYCLES = 48;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    t_mix_in          in_word   = '0;
    logic             out_valid;
    logic             out_ready = 1'b1;
    t_mix_out         out_word;
    logic             cfg_we    = 1'b0;
    logic [IDX_W-1:0] cfg_index = REG_SPEED_GAIN;
    logic [CFG_W-1:0] cfg_data  = '0;

    // bench copy of the mixer state and registers
    int          gain_q   = UNITY_Q14;
    int          dead_q   = 1639;
    int          count_ms = 0;

    t_mix_out    speed_q[$];
    int          miss_cnt  = 0;
    int unsigned live_cnt  = 0;
    bit          quiet     = 1'b0;
    int          stall_left = 0;

    differential_drive_mixer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        #6_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic int pick_gap();
        int roll;
        if (quiet) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // applies one word to the bench mixer, returns 1 when a result word follows
    function automatic bit mix_speeds(input t_mix_in w, output t_mix_out r);
        int          x, y, nrm, trn, lf, rt, ax, ay, top;
        longint      sq, trial;
        r = '0;
        if (w.operation == OP_TICK) begin
            if (count_ms == 0) return 1'b0;
            count_ms--;
            if (count_ms != 0) return 1'b0;
            r.timed_out = 1'b1;
            return 1'b1;
        end
        x = w.x_axis;
        y = w.y_axis;
        if ((x < 0 ? -x : x) < dead_q) x = 0;
        if ((y < 0 ? -y : y) < dead_q) y = 0;
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        sq = longint'(x) * x + longint'(y) * y;
        nrm = 0;
        for (int b = 15; b >= 0; b--) begin
            trial = longint'(nrm | (1 << b));
            if (trial * trial <= sq) nrm = int'(trial);
        end
        trn = nrm - ay;
        if (x < 0) begin
            nrm = -nrm;
            trn = -trn;
        end
        // pivot on the spot
        if (x == 0 && y != 0) trn = -nrm;
        if (y < 0) begin
            lf = nrm;
            rt = trn;
        end else begin
            lf = trn;
            rt = nrm;
        end
        top = (lf < 0 ? -lf : lf);
        if ((rt < 0 ? -rt : rt) > top) top = (rt < 0 ? -rt : rt);
        // renormalize, division truncates toward zero
        if (top > UNITY_Q14) begin
            lf = int'(longint'(lf) * UNITY_Q14 / top);
            rt = int'(longint'(rt) * UNITY_Q14 / top);
        end
        lf = int'(longint'(lf) * gain_q / UNITY_Q14);
        rt = int'(longint'(rt) * gain_q / UNITY_Q14);
        if (w.duration_ms != 0 && (x != 0 || y != 0)) count_ms = int'(w.duration_ms);
        else count_ms = 0;
        r.left_speed  = lf[15:0];
        r.right_speed = rt[15:0];
        return 1'b1;
    endfunction

    function automatic t_mix_in cmd_word(input int x, input int y, input int dur);
        t_mix_in w;
        w.operation   = OP_COMMAND;
        w.x_axis      = x[15:0];
        w.y_axis      = y[15:0];
        w.duration_ms = dur[15:0];
        return w;
    endfunction

    // the axis and duration fields of a tick carry noise
    function automatic t_mix_in tick_word();
        t_mix_in w;
        w.operation   = OP_TICK;
        w.x_axis      = 16'($urandom);
        w.y_axis      = 16'($urandom);
        w.duration_ms = 16'($urandom);
        return w;
    endfunction

    function automatic int rand_axis();
        int picks[7] = '{-32768, -16384, -1, 0, 1, 16384, 32767};
        int v;
        case ($urandom_range(0, 5))
            0: return int'($urandom_range(0, 65535)) - 32768;
            1: begin
                v = dead_q + int'($urandom_range(0, 4)) - 2;
                if (v > 32767) v = 32767;
                return $urandom_range(0, 1) ? -v : v;
            end
            2: return picks[$urandom_range(0, 6)];
            default: return int'($urandom_range(0, 40000)) - 20000;
        endcase
    endfunction

    function automatic int rand_duration();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5) return 0;
        if (roll < 9) return $urandom_range(1, 10);
        return $urandom_range(0, 65535);
    endfunction

    task automatic send_word(input t_mix_in w);
        int       gap;
        t_mix_out r;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        live_cnt++;
        if (mix_speeds(w, r)) speed_q.push_back(r);
    endtask

    // always waits for the clock before checking the queue, so valid never drops and rises in one step
    task automatic wait_speeds_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (speed_q.size() != 0) @(posedge clk);
    endtask

    task automatic set_config(input int gain_raw, input int dead_raw);
        wait_speeds_drained();
        // settle before the writes; a tick that makes no word is not held in work
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SPEED_GAIN;
        cfg_data  <= gain_raw[CFG_W-1:0];
        @(posedge clk);
        cfg_index <= REG_DEAD_ZONE;
        cfg_data  <= dead_raw[CFG_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        gain_q = gain_raw[CFG_W-1:0] > UNITY_Q14 ? UNITY_Q14 : int'(gain_raw[CFG_W-1:0]);
        dead_q = int'(dead_raw[CFG_W-1:0]);
    endtask

    task automatic test_directed_vectors();
        send_word(cmd_word(0, 0, 0));
        send_word(cmd_word(32767, 0, 0));
        send_word(cmd_word(-32768, 0, 0));
        send_word(cmd_word(0, 32767, 0));
        send_word(cmd_word(0, -32768, 0));
        send_word(cmd_word(32767, 32767, 0));
        send_word(cmd_word(-32768, -32768, 0));
        send_word(cmd_word(-32768, 32767, 0));
        send_word(cmd_word(16384, 16384, 0));
        send_word(cmd_word(10000, -5000, 0));
        send_word(cmd_word(-10000, 5000, 0));
        // just below and at the dead zone edge
        send_word(cmd_word(1638, -1638, 0));
        send_word(cmd_word(1639, -1639, 0));
    endtask

    task automatic test_countdown();
        send_word(tick_word());
        send_word(cmd_word(8000, 0, 3));
        repeat (4) send_word(tick_word());
        // long countdown cancelled by a zero vector
        send_word(cmd_word(8000, -3000, 65535));
        send_word(tick_word());
        send_word(cmd_word(0, 0, 5));
        send_word(tick_word());
        // vector inside the dead zone does not arm
        send_word(cmd_word(100, 100, 4));
        send_word(tick_word());
        // a new command reloads the count
        send_word(cmd_word(-9000, 9000, 2));
        send_word(cmd_word(5000, 5000, 1));
        send_word(tick_word());
        send_word(cmd_word(0, 12000, 2));
        repeat (2) send_word(tick_word());
    endtask

    task automatic test_config_extremes();
        set_config(0, 0);
        send_word(cmd_word(1, 0, 0));
        send_word(cmd_word(-1, -1, 0));
        send_word(cmd_word(12000, 3000, 0));
        // zero vector with no dead zone does not arm
        send_word(cmd_word(0, 0, 3));
        send_word(tick_word());
        // gain write above one saturates
        set_config(32767, 16384);
        send_word(cmd_word(16383, 16384, 0));
        send_word(cmd_word(-16384, 16383, 0));
        send_word(cmd_word(32767, 32767, 0));
        set_config(8191, 32767);
        send_word(cmd_word(-32768, 100, 0));
        send_word(cmd_word(32767, -32768, 1));
        send_word(tick_word());
        set_config(1, 1);
        send_word(cmd_word(16384, 0, 0));
        send_word(cmd_word(-16384, 0, 0));
        send_word(cmd_word(0, 1, 0));
    endtask

    task automatic send_random_burst();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            // command with a nonzero duration followed by its ticks
            send_word(cmd_word(rand_axis(), rand_axis(), $urandom_range(1, 6)));
            repeat ($urandom_range(0, 8)) send_word(tick_word());
        end else if (roll < 85) begin
            send_word(cmd_word(rand_axis(), rand_axis(), rand_duration()));
        end else begin
            send_word(tick_word());
        end
    endtask

    task automatic test_random_traffic();
        int unsigned target;
        target = live_cnt;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_config(UNITY_Q14, 1639);
                1: set_config($urandom_range(0, 32767), $urandom_range(0, 3000));
                2: set_config($urandom_range(0, UNITY_Q14), 1639);
                3: set_config(32767, 16384);
                4: set_config($urandom_range(0, UNITY_Q14), $urandom_range(0, 32767));
                default: set_config($urandom_range(1, 16383), 0);
            endcase
            quiet = (ph == 2);
            target += 236;
            while (live_cnt < target) begin
                send_random_burst();
                if ($urandom_range(0, 99) == 0) wait_speeds_drained();
            end
        end
        quiet = 1'b0;
    endtask

    always @(posedge clk) begin
        if (!rst_n || quiet) begin
            out_ready  <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            out_ready  <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    always @(posedge clk) begin : check_words
        t_mix_out want;
        if (rst_n && out_valid && out_ready) begin
            if (speed_q.size() == 0) begin
                $display("%0t: word with nothing expected, actual left %0d right %0d stop %0b",
                         $time, out_word.left_speed, out_word.right_speed,
                         out_word.timed_out);
                miss_cnt++;
            end else begin
                want = speed_q.pop_front();
                if (out_word.left_speed !== want.left_speed) begin
                    $display("%0t: left_speed expected %0d actual %0d",
                             $time, want.left_speed, out_word.left_speed);
                    miss_cnt++;
                end
                if (out_word.right_speed !== want.right_speed) begin
                    $display("%0t: right_speed expected %0d actual %0d",
                             $time, want.right_speed, out_word.right_speed);
                    miss_cnt++;
                end
                if (out_word.timed_out !== want.timed_out) begin
                    $display("%0t: timed_out expected %0b actual %0b",
                             $time, want.timed_out, out_word.timed_out);
                    miss_cnt++;
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_vectors();
        test_countdown();
        test_config_extremes();
        test_random_traffic();
        wait_speeds_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (miss_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
